FILE: sv/assert_macros.svh
// Assertion macros shared by the chunk pool RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Concurrent assertion of an implication (use |-> or |=> inside prop).
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) cons) else $error(msg);

`endif

FILE: sv/fcfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fixed chunk free list allocator.
// Used by fcfl_store and fixed_chunk_free_list_allocator_core; depends on nothing.
package fcfl_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

    // Request kinds carried on s_tuser.
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Configuration port.
    localparam int          CFG_ADDR_W        = 3;
    localparam logic        REG_CHUNK_DATA    = 1'b0;  // word index of chunk_data_bytes
    localparam logic [15:0] CHUNK_DATA_RESET  = 16'd496;

    // Commands from the control logic to the state memories.
    typedef struct packed {
        logic rd_en;     // read both memories at their read addresses
        logic use_we;    // write the in-use flag memory
        logic use_wbit;  // flag value to write
        logic link_we;   // write the link memory
    } fcfl_mem_cmd_t;

    // Status returned by the state memories.
    typedef struct packed {
        logic init_busy; // clearing pass after reset still running
    } fcfl_mem_status_t;

endpackage

FILE: sv/fcfl_store.sv
`timescale 1ns / 1ps
// State memories of the chunk pool: the in-use flags and the free-list links.
// Depends on fcfl_pkg for the command and status structs.
module fcfl_store #(
    parameter int NUM_CHUNKS = 256,
    parameter int IDX_W      = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fcfl_pkg::fcfl_mem_cmd_t  cmd,
    input  logic [IDX_W-1:0]         use_raddr,
    input  logic [IDX_W-1:0]         link_raddr,
    input  logic [IDX_W-1:0]         use_waddr,
    input  logic [IDX_W-1:0]         link_waddr,
    input  logic [IDX_W-1:0]         link_wdata,
    output logic                     use_rdata,
    output logic [IDX_W-1:0]         link_rdata,
    output fcfl_pkg::fcfl_mem_status_t status
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHUNKS - 1);

    logic             use_mem  [NUM_CHUNKS];
    logic [IDX_W-1:0] link_mem [NUM_CHUNKS];

    logic             init_busy_reg, init_busy_next;
    logic [IDX_W-1:0] init_cnt_reg, init_cnt_next;

    logic             use_we_mux, use_wbit_mux, link_we_mux;
    logic [IDX_W-1:0] use_waddr_mux, link_waddr_mux, link_wdata_mux;
    logic             use_rdata_reg;
    logic [IDX_W-1:0] link_rdata_reg;

    // The clearing pass walks every entry once: flag cleared, link to the next entry, the last one to entry 0.
    always_comb begin
        init_busy_next = init_busy_reg;
        init_cnt_next  = init_cnt_reg;
        if (init_busy_reg) begin
            init_cnt_next = init_cnt_reg + 1'b1;
            if (init_cnt_reg == LAST_IDX) begin
                init_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
        end else begin
            init_busy_reg <= init_busy_next;
            init_cnt_reg  <= init_cnt_next;
        end
    end

    always_comb begin
        if (init_busy_reg) begin
            use_we_mux     = 1'b1;
            use_wbit_mux   = 1'b0;
            use_waddr_mux  = init_cnt_reg;
            link_we_mux    = 1'b1;
            link_waddr_mux = init_cnt_reg;
            link_wdata_mux = (init_cnt_reg == LAST_IDX) ? '0 : init_cnt_reg + 1'b1;
        end else begin
            use_we_mux     = cmd.use_we;
            use_wbit_mux   = cmd.use_wbit;
            use_waddr_mux  = use_waddr;
            link_we_mux    = cmd.link_we;
            link_waddr_mux = link_waddr;
            link_wdata_mux = link_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (use_we_mux) begin
            use_mem[use_waddr_mux] <= use_wbit_mux;
        end
        if (cmd.rd_en) begin
            use_rdata_reg <= use_mem[use_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we_mux) begin
            link_mem[link_waddr_mux] <= link_wdata_mux;
        end
        if (cmd.rd_en) begin
            link_rdata_reg <= link_mem[link_raddr];
        end
    end

    assign use_rdata        = use_rdata_reg;
    assign link_rdata       = link_rdata_reg;
    assign status.init_busy = init_busy_reg;

endmodule

FILE: sv/fixed_chunk_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Fixed-size chunk pool allocator: top level with the request control and the APB register.
// Depends on fcfl_pkg, fcfl_store and assert_macros.svh.
//
// This block manages a pool of NUM_CHUNKS equal chunks with a first-in-first-out
// free list. A word on the slave stream is one request: s_tuser selects allocate
// or release, and each request produces exactly one result word on the master
// stream carrying the granted chunk index, a status code and the free and busy
// counts after the request. Allocation grants the chunk at the head of the free
// list unless the byte count exceeds chunk_data_bytes or no chunk is free;
// release appends an in-use chunk to the tail of the free list. In the accept
// cycle of a request the in-use flag and link memories are read, and in the
// next cycle their registered read data returns. When the output register is
// free, the memories are written back and the result is loaded into it. Only
// then is a new request taken, so a request is not accepted before the last
// one is through; the wait is longer while a result waits on m_tready with the
// next request already loaded. After reset a clearing pass over all NUM_CHUNKS
// entries initializes both memories; s_tready stays low during it, while register
// writes on the APB port are taken at any time.
`include "assert_macros.svh"

module fixed_chunk_free_list_allocator_core #(
    parameter int NUM_CHUNKS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // request_bytes[15:0], release_chunk[24:16], zero
    input  logic [0:0]                      s_tuser,  // req_type[0]
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // chunk_index[7:0], status[10:8],
                                                      // free_chunks[19:11], busy_chunks[28:20], zero
    // Register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fcfl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int CNT_W = $clog2(NUM_CHUNKS + 1);

    // Control states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;

    // Request held during execution.
    logic        req_type_reg;
    logic [15:0] req_bytes_reg;
    logic [8:0]  req_rel_reg;

    // Free-list pointers and counts.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0] busy_cnt_reg, busy_cnt_next;

    // Configuration register.
    logic [15:0] chunk_data_reg;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_idx_reg, out_idx_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [8:0]  out_free_reg, out_free_next;
    logic [8:0]  out_busy_reg, out_busy_next;

    // Memory interface.
    fcfl_pkg::fcfl_mem_cmd_t    mem_cmd;
    fcfl_pkg::fcfl_mem_status_t mem_status;
    logic                       use_rdata;
    logic [IDX_W-1:0]           link_rdata;
    logic [IDX_W-1:0]           rel_idx;

    logic s_accept, commit, grant_ok, release_ok, rel_outside;

    // ------------------------------------------------------------------
    // Register port. Writes land when the access phase completes; pready
    // is tied high so every access finishes without wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_data_reg <= fcfl_pkg::CHUNK_DATA_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == fcfl_pkg::REG_CHUNK_DATA)) begin
            chunk_data_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == fcfl_pkg::REG_CHUNK_DATA) ? {16'h0000, chunk_data_reg} : '0;

    // ------------------------------------------------------------------
    // Handshakes. A request is taken only in the idle state and outside the clearing
    // pass; the result of the previous one may still be waiting in the output register.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE) && !mem_status.init_busy;
    assign s_accept = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);

    assign rel_idx     = IDX_W'(req_rel_reg);
    assign rel_outside = 32'(req_rel_reg) >= 32'(NUM_CHUNKS);

    // Both outcomes that change the pool; a release also checks the registered in-use flag.
    assign grant_ok   = (req_type_reg == fcfl_pkg::REQ_ALLOC) &&
                        (req_bytes_reg <= chunk_data_reg) && (free_cnt_reg != '0);
    assign release_ok = (req_type_reg == fcfl_pkg::REQ_RELEASE) && !rel_outside && use_rdata;

    // The read addresses come straight from the incoming word and the current
    // head, so the read data is ready in the execute cycle. Writes from one
    // request finish before the next request can issue its reads.
    always_comb begin
        mem_cmd.rd_en    = s_accept;
        mem_cmd.use_we   = commit && (grant_ok || release_ok);
        mem_cmd.use_wbit = grant_ok;
        mem_cmd.link_we  = commit && release_ok && (free_cnt_reg != '0);
    end

    fcfl_store #(
        .NUM_CHUNKS (NUM_CHUNKS),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (mem_cmd),
        .use_raddr  (IDX_W'(s_tdata[24:16])),
        .link_raddr (head_reg),
        .use_waddr  (grant_ok ? head_reg : rel_idx),
        .link_waddr (tail_reg),
        .link_wdata (rel_idx),
        .use_rdata  (use_rdata),
        .link_rdata (link_rdata),
        .status     (mem_status)
    );

    // ------------------------------------------------------------------
    // Execute step: update the pointers and counts and build the result.
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_cnt_next   = free_cnt_reg;
        busy_cnt_next   = busy_cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        out_busy_next   = out_busy_reg;

        if (s_accept) begin
            state_next = ST_EXEC;
        end

        if (commit) begin
            state_next   = ST_IDLE;
            m_valid_next = 1'b1;
            out_idx_next = 8'h00;

            if (req_type_reg == fcfl_pkg::REQ_ALLOC) begin
                priority if (req_bytes_reg > chunk_data_reg) begin
                    out_status_next = fcfl_pkg::ST_TOO_LARGE;
                end else if (free_cnt_reg == '0) begin
                    out_status_next = fcfl_pkg::ST_EMPTY;
                end else begin
                    out_status_next = fcfl_pkg::ST_OK;
                    out_idx_next    = 8'(head_reg);
                    head_next       = link_rdata;
                    free_cnt_next   = free_cnt_reg - 1'b1;
                    busy_cnt_next   = busy_cnt_reg + 1'b1;
                end
            end else begin
                priority if (rel_outside) begin
                    out_status_next = fcfl_pkg::ST_OUTSIDE;
                end else if (!use_rdata) begin
                    out_status_next = fcfl_pkg::ST_NOT_ALLOC;
                end else begin
                    out_status_next = fcfl_pkg::ST_OK;
                    // With an empty list the released chunk becomes the head too.
                    if (free_cnt_reg == '0) begin
                        head_next = rel_idx;
                    end
                    tail_next     = rel_idx;
                    free_cnt_next = free_cnt_reg + 1'b1;
                    if (busy_cnt_reg != '0) begin
                        busy_cnt_next = busy_cnt_reg - 1'b1;
                    end
                end
            end

            out_free_next = 9'(free_cnt_next);
            out_busy_next = 9'(busy_cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= IDX_W'(NUM_CHUNKS - 1);
            free_cnt_reg <= CNT_W'(NUM_CHUNKS);
            busy_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            free_cnt_reg <= free_cnt_next;
            busy_cnt_reg <= busy_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_type_reg  <= s_tuser[0];
            req_bytes_reg <= s_tdata[15:0];
            req_rel_reg   <= s_tdata[24:16];
        end
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
        out_busy_reg   <= out_busy_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_busy_reg, out_free_reg, out_status_reg, out_idx_reg};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_sum, (32'(free_cnt_reg) + 32'(busy_cnt_reg)) == 32'(NUM_CHUNKS), "free and busy counts do not add up to the pool size")
    `ASSERT_IMPLY(a_accept_exec, s_accept, |=> (state_reg == ST_EXEC) && m_valid_reg == $past(m_valid_reg && !m_tready), "accepted request did not enter execution")
    `ASSERT_IMPLY(a_grant_count, commit && grant_ok, |=> free_cnt_reg == $past(free_cnt_reg) - 1'b1, "grant did not take one chunk off the free count")
    `ASSERT_IMPLY(a_no_accept_init, mem_status.init_busy, |-> !s_tready, "request taken during the clearing pass")

endmodule
